// ===== hw/rtl/tpb_pkg.sv =====
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared types and codes for the tagged packet buffer pool: word layouts,
// action and status codes, register indexes and the cell link record.
// ----------------------------------------------------------------------------
package tpb_pkg;

  // action codes
  localparam logic [3:0] ACT_ALLOC     = 4'd0;
  localparam logic [3:0] ACT_FREE      = 4'd1;
  localparam logic [3:0] ACT_DROP_CRT  = 4'd2;
  localparam logic [3:0] ACT_DROP_OWN  = 4'd3;
  localparam logic [3:0] ACT_SENT      = 4'd4;
  localparam logic [3:0] ACT_RECEIVED  = 4'd5;
  localparam logic [3:0] ACT_DATA      = 4'd6;
  localparam logic [3:0] ACT_DATA_DEST = 4'd7;
  localparam logic [3:0] ACT_BEACON    = 4'd8;
  localparam logic [3:0] ACT_HANDOVER  = 4'd9;

  // status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_UNSYNCED = 3'd1;
  localparam logic [2:0] STS_NONE     = 3'd2;
  localparam logic [2:0] STS_UNUSED   = 3'd3;
  localparam logic [2:0] STS_NOSLOT   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_CODE_NULL   = 3'd0;
  localparam logic [2:0] REG_CODE_POOL   = 3'd1;
  localparam logic [2:0] REG_CODE_MAC    = 3'd2;
  localparam logic [2:0] REG_CODE_S2M    = 3'd3;
  localparam logic [2:0] REG_CODE_M2S    = 3'd4;
  localparam logic [2:0] REG_CODE_SIXTOP = 3'd5;

  // register reset values
  localparam logic [5:0] RST_CODE_NULL   = 6'd0;
  localparam logic [5:0] RST_CODE_POOL   = 6'd3;
  localparam logic [5:0] RST_CODE_MAC    = 6'd9;
  localparam logic [5:0] RST_CODE_S2M    = 6'd10;
  localparam logic [5:0] RST_CODE_M2S    = 6'd11;
  localparam logic [5:0] RST_CODE_SIXTOP = 6'd12;

  typedef struct packed {
    logic [3:0]  action;
    logic [5:0]  component;
    logic [4:0]  entry_index;
    logic [15:0] dest_addr;
    logic        synced;
  } in_word_t;

  typedef struct packed {
    logic       found;
    logic [4:0] result_index;
    logic [2:0] status;
  } out_word_t;

  // component codes from the register file
  typedef struct packed {
    logic [5:0] code_null;
    logic [5:0] code_pool;
    logic [5:0] code_mac;
    logic [5:0] code_sixtop_to_mac;
    logic [5:0] code_mac_to_sixtop;
    logic [5:0] code_sixtop;
  } codes_t;

  // command broadcast to every cell
  typedef struct packed {
    logic        exec;
    logic [3:0]  action;
    logic [5:0]  component;
    logic [4:0]  entry_index;
    logic [15:0] dest_addr;
    logic        alloc_ok;
  } cell_cmd_t;

  // record handed from one cell to the next
  typedef struct packed {
    logic       claimed;
    logic [4:0] hit_index;
    logic       unused;
  } link_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } fsm_t;

endpackage

// ===== hw/rtl/tpb_cell.sv =====
// ----------------------------------------------------------------------------
// tpb_cell
// One pool slot: owner, creator and destination, its match logic and one
// stage of the lowest-slot-wins priority chain.
// ----------------------------------------------------------------------------
module tpb_cell import tpb_pkg::*; #(
  parameter logic [4:0] CELL_IDX = 5'd0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  codes_t    codes,
  input  cell_cmd_t cmd,
  input  link_t     link_in,
  output link_t     link_out
);

  logic [5:0]  owner_r, owner_nxt;
  logic [5:0]  creator_r, creator_nxt;
  logic [15:0] dest_r, dest_nxt;
  logic        sel, is_free, match, hit;

  assign sel     = (cmd.entry_index == CELL_IDX);
  assign is_free = (owner_r == codes.code_null);

  // local match for allocation and lookups
  always_comb begin
    case (cmd.action)
      ACT_ALLOC:     match = cmd.alloc_ok && is_free;
      ACT_SENT:      match = (owner_r == codes.code_mac_to_sixtop) &&
                             (creator_r != codes.code_mac);
      ACT_RECEIVED:  match = (owner_r == codes.code_mac_to_sixtop) &&
                             (creator_r == codes.code_mac);
      ACT_DATA:      match = (owner_r == codes.code_sixtop_to_mac) &&
                             (creator_r != codes.code_sixtop);
      ACT_DATA_DEST: match = (owner_r == codes.code_sixtop_to_mac) &&
                             (creator_r != codes.code_sixtop) &&
                             (dest_r == cmd.dest_addr);
      ACT_BEACON:    match = (owner_r == codes.code_sixtop_to_mac) &&
                             (creator_r == codes.code_sixtop);
      default:       match = 1'b0;
    endcase
  end

  // priority chain: first matching cell takes the word
  assign hit = match && !link_in.claimed;
  always_comb begin
    link_out.claimed   = link_in.claimed || match;
    link_out.hit_index = hit ? CELL_IDX : link_in.hit_index;
    link_out.unused    = link_in.unused ||
                         ((cmd.action == ACT_FREE) && sel && is_free);
  end

  // slot update
  always_comb begin
    owner_nxt   = owner_r;
    creator_nxt = creator_r;
    dest_nxt    = dest_r;
    if (cmd.exec) begin
      case (cmd.action)
        ACT_ALLOC: begin
          if (hit) begin
            owner_nxt   = codes.code_pool;
            creator_nxt = cmd.component;
          end
        end
        ACT_FREE: begin
          if (sel) begin
            owner_nxt   = codes.code_null;
            creator_nxt = codes.code_null;
          end
        end
        ACT_DROP_CRT: begin
          if (creator_r == cmd.component) begin
            owner_nxt   = codes.code_null;
            creator_nxt = codes.code_null;
          end
        end
        ACT_DROP_OWN: begin
          if (owner_r == cmd.component) begin
            owner_nxt   = codes.code_null;
            creator_nxt = codes.code_null;
          end
        end
        ACT_HANDOVER: begin
          if (sel) begin
            owner_nxt = cmd.component;
            dest_nxt  = cmd.dest_addr;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r   <= RST_CODE_NULL;
      creator_r <= RST_CODE_NULL;
    end else begin
      owner_r   <= owner_nxt;
      creator_r <= creator_nxt;
    end
  end

  // destination has no reset
  always_ff @(posedge clk) begin
    dest_r <= dest_nxt;
  end

endmodule

// ===== hw/rtl/tagged_packet_buffer_pool_unit.sv =====
// ----------------------------------------------------------------------------
// tagged_packet_buffer_pool_unit
// Packet buffer pool: a chain of slot cells with a priority chain for
// allocation and first-match lookups, a register file and an output register.
// ----------------------------------------------------------------------------
// Sequencing: a word accepted into the command register executes in the cell
// chain in the EXEC state, once the output register is free, and its result
// is held in the output register; no new word is taken until it executes.
// Reset (synchronous, active low): all slots free, registers at their reset
// codes, no result pending.
module tagged_packet_buffer_pool_unit import tpb_pkg::*; #(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [5:0] cfg_wdata
);

  fsm_t      state_r, state_nxt;
  in_word_t  cmd_r;
  codes_t    codes_r;
  out_word_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      in_fire, exec, in_range, alloc_ok;
  cell_cmd_t cmd;
  link_t     links [POOL_SLOTS+1];

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.code_null          <= RST_CODE_NULL;
      codes_r.code_pool          <= RST_CODE_POOL;
      codes_r.code_mac           <= RST_CODE_MAC;
      codes_r.code_sixtop_to_mac <= RST_CODE_S2M;
      codes_r.code_mac_to_sixtop <= RST_CODE_M2S;
      codes_r.code_sixtop        <= RST_CODE_SIXTOP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_NULL:   codes_r.code_null          <= cfg_wdata;
        REG_CODE_POOL:   codes_r.code_pool          <= cfg_wdata;
        REG_CODE_MAC:    codes_r.code_mac           <= cfg_wdata;
        REG_CODE_S2M:    codes_r.code_sixtop_to_mac <= cfg_wdata;
        REG_CODE_M2S:    codes_r.code_mac_to_sixtop <= cfg_wdata;
        REG_CODE_SIXTOP: codes_r.code_sixtop        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: if (exec) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    exec     = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: exec = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // command register
  always_ff @(posedge clk) begin
    if (in_fire) cmd_r <= in_data;
  end

  assign alloc_ok = cmd_r.synced || (cmd_r.component <= codes_r.code_mac);
  assign in_range = ({1'b0, cmd_r.entry_index} < 6'(POOL_SLOTS));

  always_comb begin
    cmd.exec        = exec;
    cmd.action      = cmd_r.action;
    cmd.component   = cmd_r.component;
    cmd.entry_index = cmd_r.entry_index;
    cmd.dest_addr   = cmd_r.dest_addr;
    cmd.alloc_ok    = alloc_ok;
  end

  // cell chain
  assign links[0] = '{claimed: 1'b0, hit_index: 5'd0, unused: 1'b0};

  for (genvar g = 0; g < POOL_SLOTS; g++) begin : g_cell
    tpb_cell #(
      .CELL_IDX (5'(g))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .codes    (codes_r),
      .cmd      (cmd),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  // result word
  always_comb begin
    out_nxt = '{found: 1'b0, result_index: 5'd0, status: STS_OK};
    case (cmd_r.action)
      ACT_ALLOC, ACT_SENT, ACT_RECEIVED, ACT_DATA, ACT_DATA_DEST, ACT_BEACON: begin
        if ((cmd_r.action == ACT_ALLOC) && !alloc_ok) begin
          out_nxt.status = STS_UNSYNCED;
        end else if (links[POOL_SLOTS].claimed) begin
          out_nxt.found        = 1'b1;
          out_nxt.result_index = links[POOL_SLOTS].hit_index;
        end else begin
          out_nxt.status = STS_NONE;
        end
      end
      ACT_FREE, ACT_HANDOVER: begin
        if (!in_range) begin
          out_nxt.status = STS_NOSLOT;
        end else begin
          out_nxt.found        = 1'b1;
          out_nxt.result_index = cmd_r.entry_index;
          if (links[POOL_SLOTS].unused) out_nxt.status = STS_UNUSED;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (exec) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/tpb_checker.sv =====
// ----------------------------------------------------------------------------
// tpb_checker
// Port-level checks on the result channel of the buffer pool, bound to the
// top level.
// ----------------------------------------------------------------------------
module tpb_checker import tpb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // no slot found means index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.result_index == 5'd0)
    else $error("nonzero index without a slot");

  // refusals and misses never report a slot
  a_fail_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STS_UNSYNCED || out_data.status == STS_NONE ||
                  out_data.status == STS_NOSLOT) |-> !out_data.found)
    else $error("failed word reports a slot");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind tagged_packet_buffer_pool_unit tpb_checker u_tpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
